/* src/lfu_pkg.sv */
package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_BITS       = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_REMOVE,
        ST_INSERT,
        ST_OUT
    } lfu_state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic hit_upd;
        logic remove;
        logic insert;
        logic out_load;
    } lfu_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic mode;
        logic need_evict;
        logic victim_ok;
        logic slot_ok;
        logic cap_zero;
    } lfu_stat_t;

endpackage

/* src/lfu_ctrl.sv */
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  lfu_stat_t stat,
    output lfu_cmd_t  cmd
);

    lfu_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.found) begin
                    cmd.hit_upd = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next = ST_OUT;
                end else if (!stat.mode || stat.cap_zero) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_OUT;
                end else if (stat.need_evict && stat.victim_ok) begin
                    cmd.remove = 1'b1;
                    state_next = ST_REMOVE;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_REMOVE: begin
                state_next = ST_INSERT;
            end
            ST_INSERT: begin
                if (stat.slot_ok) begin
                    cmd.insert = 1'b1;
                end
                cmd.out_load = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* src/lfu_dp.sv */
module lfu_dp
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cap_we,
    input  logic [CAP_BITS-1:0]   cap_wdata,
    input  logic                  in_mode,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [VALUE_BITS-1:0] in_value,
    input  lfu_cmd_t              cmd,
    output lfu_stat_t             stat,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] read_value,
    output logic                  evicted,
    output logic [KEY_BITS-1:0]   evicted_key
);

    localparam int IW = $clog2(ENTRIES);
    localparam int OW = $clog2(ENTRIES + 1);

    logic                  valid_reg [ENTRIES];
    logic [KEY_BITS-1:0]   key_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] data_reg  [ENTRIES];
    logic [COUNT_BITS-1:0] cnt_reg   [ENTRIES];
    logic [IW-1:0]         rank_reg  [ENTRIES];

    logic [OW-1:0]         occ_reg;
    logic [CAP_BITS-1:0]   cap_reg;
    logic                  mode_reg;
    logic [KEY_BITS-1:0]   key_in_reg;
    logic [VALUE_BITS-1:0] val_in_reg;
    logic [OW-1:0]         idx_reg;
    logic                  found_reg, vic_ok_reg, slot_ok_reg;
    logic [IW-1:0]         found_idx_reg, vic_idx_reg, slot_idx_reg;
    logic                  ev_reg;
    logic [KEY_BITS-1:0]   ev_key_reg;

    logic [IW-1:0] si;
    logic          better;
    logic [OW-1:0] cap_eff;
    logic [IW-1:0] ref_rank;

    assign si = idx_reg[IW-1:0];
    assign better = !vic_ok_reg
        || cnt_reg[si] < cnt_reg[vic_idx_reg]
        || (cnt_reg[si] == cnt_reg[vic_idx_reg] && rank_reg[si] > rank_reg[vic_idx_reg]);
    assign cap_eff = (32'(cap_reg) > ENTRIES) ? OW'(ENTRIES) : OW'(cap_reg);
    assign ref_rank = cmd.remove ? rank_reg[vic_idx_reg] : rank_reg[found_idx_reg];

    always_comb begin
        stat            = '0;
        stat.scan_done  = (idx_reg == OW'(ENTRIES - 1));
        stat.found      = found_reg;
        stat.mode       = mode_reg;
        stat.need_evict = (occ_reg >= cap_eff);
        stat.victim_ok  = vic_ok_reg;
        stat.slot_ok    = slot_ok_reg;
        stat.cap_zero   = (cap_eff == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_BITS'(16);
            occ_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            if (cap_we) begin
                cap_reg <= cap_wdata;
            end
            if (cmd.start) begin
                mode_reg    <= in_mode;
                key_in_reg  <= in_key;
                val_in_reg  <= in_value;
                idx_reg     <= '0;
                found_reg   <= 1'b0;
                vic_ok_reg  <= 1'b0;
                slot_ok_reg <= 1'b0;
                ev_reg      <= 1'b0;
                ev_key_reg  <= '0;
            end
            if (cmd.scan) begin
                if (!stat.scan_done) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (valid_reg[si]) begin
                    if (!found_reg && key_reg[si] == key_in_reg) begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= si;
                    end
                    if (better) begin
                        vic_ok_reg  <= 1'b1;
                        vic_idx_reg <= si;
                    end
                end else if (!slot_ok_reg) begin
                    slot_ok_reg  <= 1'b1;
                    slot_idx_reg <= si;
                end
            end
            if (cmd.hit_upd || cmd.remove) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i]) begin
                        if (cmd.hit_upd && rank_reg[i] < ref_rank) begin
                            rank_reg[i] <= rank_reg[i] + 1'b1;
                        end
                        if (cmd.remove && rank_reg[i] > ref_rank) begin
                            rank_reg[i] <= rank_reg[i] - 1'b1;
                        end
                    end
                end
            end
            if (cmd.hit_upd) begin
                rank_reg[found_idx_reg] <= '0;
                if (mode_reg) begin
                    data_reg[found_idx_reg] <= val_in_reg;
                end
                if (cnt_reg[found_idx_reg] != '1) begin
                    cnt_reg[found_idx_reg] <= cnt_reg[found_idx_reg] + 1'b1;
                end
            end
            if (cmd.remove) begin
                valid_reg[vic_idx_reg] <= 1'b0;
                ev_reg       <= 1'b1;
                ev_key_reg   <= key_reg[vic_idx_reg];
                slot_ok_reg  <= 1'b1;
                if (!slot_ok_reg) begin
                    slot_idx_reg <= vic_idx_reg;
                end
                occ_reg <= occ_reg - 1'b1;
            end
            if (cmd.insert) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i]) begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
                valid_reg[slot_idx_reg] <= 1'b1;
                key_reg[slot_idx_reg]   <= key_in_reg;
                data_reg[slot_idx_reg]  <= val_in_reg;
                cnt_reg[slot_idx_reg]   <= COUNT_BITS'(1);
                rank_reg[slot_idx_reg]  <= '0;
                occ_reg <= occ_reg + 1'b1;
            end
            if (cmd.out_load) begin
                hit         <= found_reg;
                read_value  <= (found_reg && !mode_reg) ? data_reg[found_idx_reg] : '0;
                evicted     <= ev_reg;
                evicted_key <= ev_key_reg;
            end
        end
    end

endmodule

/* src/lfu_cache_lru_tiebreak_core.sv */
// LFU key/value store with LRU tiebreak. One access at a time: after the accept
// an item passes the scan, then the decide state, then on eviction the remove
// state and for a put of a new key the insert state, and last the output beat,
// which is held while m_tready is low. The scan checks one entry per cycle for
// key match, victim and free slot. Capacity is to be written via cfg_we only
// while idle; the user is bound to this, the block does not enforce it. Capacity
// reads 16 after reset and values above ENTRIES act as ENTRIES.
module lfu_cache_lru_tiebreak_core
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int SW = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int MW = ((1 + VALUE_BITS + KEY_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CAP_BITS-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SW-1:0]       s_tdata,   // lookup_key, write_value
    input  logic                s_tuser,   // mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [MW-1:0]       m_tdata,   // read_value, evicted, evicted_key
    output logic                m_tuser    // hit
);

    lfu_cmd_t              cmd;
    lfu_stat_t             stat;
    logic                  hit, evicted;
    logic [VALUE_BITS-1:0] read_value;
    logic [KEY_BITS-1:0]   evicted_key;

    lfu_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lfu_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cap_we      (cfg_we),
        .cap_wdata   (cfg_wdata),
        .in_mode     (s_tuser),
        .in_key      (s_tdata[KEY_BITS-1:0]),
        .in_value    (s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
        .cmd         (cmd),
        .stat        (stat),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    assign m_tuser = hit;
    assign m_tdata = MW'({evicted_key, evicted, read_value});

endmodule
